/* hw/rtl/sle_pkg.sv */
// shared constants, types and command word for the serial line editor
`default_nettype none
package sle_pkg;

    // line store size, one place is kept free
    localparam int LINE_BYTES  = 32;
    localparam int ADDR_W      = $clog2(LINE_BYTES);
    localparam int CNT_W       = ADDR_W;
    localparam int K_W         = CNT_W + 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LINE_BYTES - 1);

    // character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // what the back end has to do for one received byte
    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_ERASE = 2'd1,
        KIND_TERM  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        rx_byte;
        logic [CNT_W-1:0]  count;
        logic              ovf;
    } cmd_t;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic       char_valid;
        logic [7:0] text_char;
        logic       line_end;
        logic       overflow;
        logic       last;
    } res_t;

endpackage
`default_nettype wire

/* hw/rtl/sle_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/sle_queue.sv */
// short command queue between front and back end
`default_nettype none
module sle_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire sle_pkg::cmd_t push_cmd,
    input  wire logic         pop,
    output sle_pkg::cmd_t     head,
    output logic              empty,
    output logic              full
);
    import sle_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sle_front.sv */
// front end: takes received bytes, keeps the fill count, writes the line store
`default_nettype none
module sle_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [7:0]                in_byte,
    input  wire logic                      q_full,
    output logic                           push,
    output sle_pkg::cmd_t                  push_cmd,
    input  wire logic                      line_done,
    output logic                           st_we,
    output logic [sle_pkg::ADDR_W-1:0]     st_waddr,
    output logic [7:0]                     st_wdata
);
    import sle_pkg::*;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             busy_reg, busy_next;
    logic             accept;
    logic             is_term, is_erase, is_print;

    assign in_ready = !q_full && !busy_reg;
    assign accept   = in_valid && in_ready;
    assign is_term  = (in_byte == CH_LF) || (in_byte == CH_CR);
    assign is_erase = (in_byte == CH_BS) || (in_byte == CH_DEL);
    assign is_print = (in_byte >= CH_SPACE) && (in_byte < CH_DEL);

    assign st_waddr = fill_reg;
    assign st_wdata = in_byte;
    assign push     = accept;

    always_comb
    begin
        fill_next         = fill_reg;
        busy_next         = busy_reg;
        st_we             = 1'b0;
        push_cmd.kind     = KIND_PLAIN;
        push_cmd.rx_byte  = in_byte;
        push_cmd.count    = fill_reg;
        push_cmd.ovf      = 1'b0;
        if (line_done)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            if (is_term)
            begin
                push_cmd.kind = KIND_TERM;
                fill_next     = '0;
                // store is locked until the back end has read the line out
                if (fill_reg != '0)
                begin
                    busy_next = 1'b1;
                end
            end
            else if (is_erase)
            begin
                if (fill_reg != '0)
                begin
                    push_cmd.kind = KIND_ERASE;
                    fill_next     = fill_reg - 1'b1;
                end
            end
            else if (is_print)
            begin
                if (fill_reg != FULL_COUNT)
                begin
                    st_we     = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    fill_next    = '0;
                    push_cmd.ovf = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            busy_reg <= busy_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sle_back.sv */
// back end: trims the stored line and emits echo and line words
`default_nettype none
module sle_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_empty,
    input  wire sle_pkg::cmd_t             head,
    output logic                           pop,
    output logic [sle_pkg::ADDR_W-1:0]     st_raddr,
    input  wire logic [7:0]                st_rdata,
    output logic                           line_done,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output sle_pkg::res_t                  out_res
);
    import sle_pkg::*;

    typedef enum logic [6:0] {
        B_IDLE    = 7'b0000001,
        B_LO_RD   = 7'b0000010,
        B_LO_CHK  = 7'b0000100,
        B_HI_RD   = 7'b0001000,
        B_HI_CHK  = 7'b0010000,
        B_EMIT_RD = 7'b0100000,
        B_EMIT    = 7'b1000000
    } bstate_t;

    bstate_t          state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic             ovalid_reg, ovalid_next;
    res_t             ores_reg, ores_next;

    logic [K_W-1:0]   necho, nline, n_last;
    logic             has_line, out_free;
    logic [7:0]       echo_ch;

    assign out_valid = ovalid_reg;
    assign out_res   = ores_reg;
    assign out_free  = !ovalid_reg || out_ready;
    assign has_line  = (cmd_reg.kind == KIND_TERM) && (cmd_reg.count != '0);
    assign nline     = K_W'(hi_reg - lo_reg);

    always_comb
    begin
        case (cmd_reg.kind)
            KIND_ERASE: necho = K_W'(4);
            KIND_TERM:  necho = K_W'(3);
            default:    necho = K_W'(1);
        endcase
        n_last = ((necho > nline) ? necho : nline) - 1'b1;
    end

    // echo sequence: the byte itself, then cr lf for a terminator or bs space bs for an erase
    always_comb
    begin
        echo_ch = cmd_reg.rx_byte;
        if (k_reg == K_W'(1))
        begin
            echo_ch = (cmd_reg.kind == KIND_TERM) ? CH_CR : CH_BS;
        end
        else if (k_reg == K_W'(2))
        begin
            echo_ch = (cmd_reg.kind == KIND_TERM) ? CH_LF : CH_SPACE;
        end
        else if (k_reg == K_W'(3))
        begin
            echo_ch = CH_BS;
        end
    end

    always_comb
    begin
        case (state_reg)
            B_LO_RD, B_LO_CHK: st_raddr = lo_reg;
            B_HI_RD, B_HI_CHK: st_raddr = hi_reg - 1'b1;
            default:           st_raddr = ADDR_W'(K_W'(lo_reg) + k_reg);
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        k_next      = k_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ores_next   = ores_reg;
        pop         = 1'b0;
        line_done   = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    k_next   = '0;
                    lo_next  = '0;
                    if ((head.kind == KIND_TERM) && (head.count != '0))
                    begin
                        hi_next    = head.count;
                        state_next = B_LO_RD;
                    end
                    else
                    begin
                        hi_next    = '0;
                        state_next = B_EMIT_RD;
                    end
                end
            end
            B_LO_RD:
            begin
                state_next = B_LO_CHK;
            end
            B_LO_CHK:
            begin
                if (st_rdata == CH_SPACE)
                begin
                    if (lo_reg + 1'b1 == cmd_reg.count)
                    begin
                        // all spaces: empty line
                        lo_next    = cmd_reg.count;
                        state_next = B_EMIT_RD;
                    end
                    else
                    begin
                        lo_next    = lo_reg + 1'b1;
                        state_next = B_LO_RD;
                    end
                end
                else
                begin
                    state_next = B_HI_RD;
                end
            end
            B_HI_RD:
            begin
                state_next = B_HI_CHK;
            end
            B_HI_CHK:
            begin
                // lo points at a non-space, so this stops above it
                if (st_rdata == CH_SPACE)
                begin
                    hi_next    = hi_reg - 1'b1;
                    state_next = B_HI_RD;
                end
                else
                begin
                    state_next = B_EMIT_RD;
                end
            end
            B_EMIT_RD:
            begin
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next          = 1'b1;
                    ores_next.echo_valid = (k_reg < necho);
                    ores_next.echo_char  = (k_reg < necho) ? echo_ch : 8'h00;
                    ores_next.char_valid = (k_reg < nline);
                    ores_next.text_char  = (k_reg < nline) ? st_rdata : 8'h00;
                    ores_next.line_end   = has_line && (k_reg == n_last);
                    ores_next.overflow   = cmd_reg.ovf;
                    ores_next.last       = (k_reg == n_last);
                    if (k_reg == n_last)
                    begin
                        line_done  = has_line;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = B_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        k_reg    <= k_next;
        ores_reg <= ores_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/serial_line_editor.sv */
// top level of the serial line editor with backspace and echo
//
// channel   dir  width  contents
// s_axis    in   8      rx_byte, one received serial byte
// m_axis    out  24+1   echo and line word, tlast on the last word of a byte
//
// the front end takes one byte a cycle while the command queue has room and no
// finished line is still being read out of the line store
// the back end fetches a command in its idle state and then, for each result word, reads
// the store and emits the word; a terminator first trims spaces from both ends of the
// stored line in read and check states; the next command is taken after the last word
// a word waits in the output register on m_axis_tready; the back end stalls until it is taken
// reset clears the fill count, queue and control state; store entries need no reset
`default_nettype none
module serial_line_editor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] echo_valid, [8:1] echo_char, [9] char_valid, [17:10] text_char,
    // [18] line_end, [19] overflow, [23:20] zero
    output logic [23:0]      m_axis_tdata,
    output logic             m_axis_tlast    // last word caused by this byte
);
    import sle_pkg::*;

    cmd_t              push_cmd, head;
    logic              push, pop, q_empty, q_full;
    logic              line_done;
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    logic [7:0]        st_wdata, st_rdata;
    res_t              res;

    sle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd),
        .line_done (line_done),
        .st_we     (st_we),
        .st_waddr  (st_waddr),
        .st_wdata  (st_wdata)
    );

    // line store
    sle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    sle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    sle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .st_raddr  (st_raddr),
        .st_rdata  (st_rdata),
        .line_done (line_done),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // word packing, highest field first, echo_valid at bit 0
    assign m_axis_tdata = {4'h0, res.overflow, res.line_end, res.text_char,
                           res.char_valid, res.echo_char, res.echo_valid};
    assign m_axis_tlast = res.last;

endmodule
`default_nettype wire
